// File: hw/rtl/sfe_pkg.sv
// Shared types and constants for the square factor extractor.
// Holds widths, the controller state type and the command/status structs.
// No dependencies.
package sfe_pkg;

    // Width of the radicand input and of the working radicand.
    localparam int DATA_WIDTH = 24;
    // Fixed result widths.
    localparam int FACTOR_W   = 12;
    localparam int OUT_RAD_W  = 24;
    // Trial divisor width: d never exceeds floor(sqrt(2^(DATA_WIDTH-1))) + 1.
    localparam int D_W        = (DATA_WIDTH + 1) / 2;
    // Width of d squared.
    localparam int SQ_W       = 2 * D_W;
    // Width of the division step counter.
    localparam int CNT_W      = $clog2(DATA_WIDTH);

    // Controller states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQUARE,
        ST_CHECK,
        ST_DIV,
        ST_TEST,
        ST_DONE
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;      // Capture a new radicand.
        logic square;    // Register d * d.
        logic div_init;  // Start a long division of rem by d * d.
        logic div_step;  // One restoring division step.
        logic test;      // Commit the quotient or advance d.
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic finish;    // No further divisor can divide the radicand.
        logic div_last;  // The current division step is the final one.
    } t_dp_status;

endpackage

// File: hw/rtl/square_factor_extractor_unit.sv
// Top level of the square factor extractor: controller plus datapath.
// Depends on sfe_pkg, sfe_ctrl and sfe_dp.
//
// Writes a signed radicand n as a*sqrt(b) by trial division with d = 2, 3, ...
// A beat is taken when start is high and busy is low; busy then stays high
// until the result has been shown. For each trial divisor the block squares
// d, compares d*d with the radicand, runs a bit-serial restoring division
// (one quotient bit per cycle) and then commits the quotient or steps d. The
// next beat can be taken in the cycle after the result. The result is on the
// output ports with o_valid high for exactly one cycle; the receiver cannot
// stall it, so it must take it then.
module square_factor_extractor_unit (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   start,
    output logic                                   busy,
    input  logic signed [sfe_pkg::DATA_WIDTH-1:0]  i_radicand,
    output logic                                   o_valid,
    output logic        [sfe_pkg::FACTOR_W-1:0]    o_outside_factor,
    output logic signed [sfe_pkg::OUT_RAD_W-1:0]   o_remaining_radicand
);

    sfe_pkg::t_dp_cmd    cmd;
    sfe_pkg::t_dp_status status;

    // Sequencer.
    sfe_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_status (status),
        .o_cmd    (cmd),
        .o_busy   (busy),
        .o_valid  (o_valid)
    );

    // Arithmetic.
    sfe_dp u_dp (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cmd                (cmd),
        .i_radicand           (i_radicand),
        .o_status             (status),
        .o_outside_factor     (o_outside_factor),
        .o_remaining_radicand (o_remaining_radicand)
    );

    // An accepted beat always makes the block busy on the next cycle.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("block not busy after accepting a beat");

    // The result strobe is only raised while the block is still busy.
    a_valid_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> busy)
        else $error("result strobe while idle");

    // After the strobe the block is idle again and the strobe drops.
    a_valid_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> (!busy && !o_valid))
        else $error("block did not return to idle after a result");

    // No division step follows a check that finds the radicand finished.
    a_no_div_when_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.div_init && status.finish) |=> !cmd.div_step)
        else $error("division started although extraction was finished");

endmodule

// File: hw/rtl/sfe_ctrl.sv
// Controller state machine for the square factor extractor.
// Sequences trial squaring, serial division and result strobe.
// Depends on sfe_pkg.
module sfe_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  sfe_pkg::t_dp_status i_status,
    output sfe_pkg::t_dp_cmd    o_cmd,
    output logic                o_busy,
    output logic                o_valid
);

    sfe_pkg::t_state r_state;
    sfe_pkg::t_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sfe_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state logic.
    always_comb begin
        n_state = r_state;
        case (r_state)
            sfe_pkg::ST_IDLE: begin
                if (i_start) begin
                    n_state = sfe_pkg::ST_SQUARE;
                end
            end
            sfe_pkg::ST_SQUARE: begin
                n_state = sfe_pkg::ST_CHECK;
            end
            sfe_pkg::ST_CHECK: begin
                if (i_status.finish) begin
                    n_state = sfe_pkg::ST_DONE;
                end else begin
                    n_state = sfe_pkg::ST_DIV;
                end
            end
            sfe_pkg::ST_DIV: begin
                if (i_status.div_last) begin
                    n_state = sfe_pkg::ST_TEST;
                end
            end
            sfe_pkg::ST_TEST: begin
                n_state = sfe_pkg::ST_SQUARE;
            end
            sfe_pkg::ST_DONE: begin
                n_state = sfe_pkg::ST_IDLE;
            end
            default: begin
                n_state = sfe_pkg::ST_IDLE;
            end
        endcase
    end

    // Output and command decode.
    always_comb begin
        o_cmd   = '0;
        o_busy  = 1'b1;
        o_valid = 1'b0;
        case (r_state)
            sfe_pkg::ST_IDLE: begin
                o_busy     = 1'b0;
                o_cmd.load = i_start;
            end
            sfe_pkg::ST_SQUARE: begin
                o_cmd.square = 1'b1;
            end
            sfe_pkg::ST_CHECK: begin
                o_cmd.div_init = 1'b1;
            end
            sfe_pkg::ST_DIV: begin
                o_cmd.div_step = 1'b1;
            end
            sfe_pkg::ST_TEST: begin
                o_cmd.test = 1'b1;
            end
            sfe_pkg::ST_DONE: begin
                o_valid = 1'b1;
            end
            default: begin
                o_busy = 1'b1;
            end
        endcase
    end

endmodule

// File: hw/rtl/sfe_dp.sv
// Datapath for the square factor extractor: radicand, trial divisor,
// squarer, restoring divider and outside factor multiplier.
// Depends on sfe_pkg.
module sfe_dp (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  sfe_pkg::t_dp_cmd                       i_cmd,
    input  logic signed [sfe_pkg::DATA_WIDTH-1:0]  i_radicand,
    output sfe_pkg::t_dp_status                    o_status,
    output logic        [sfe_pkg::FACTOR_W-1:0]    o_outside_factor,
    output logic signed [sfe_pkg::OUT_RAD_W-1:0]   o_remaining_radicand
);

    logic signed [sfe_pkg::DATA_WIDTH-1:0] r_rem;
    logic        [sfe_pkg::D_W-1:0]        r_d;
    logic        [sfe_pkg::SQ_W-1:0]       r_sq;
    logic        [sfe_pkg::FACTOR_W-1:0]   r_factor;
    logic        [sfe_pkg::SQ_W-1:0]       r_part;
    logic        [sfe_pkg::DATA_WIDTH-1:0] r_quo;
    logic        [sfe_pkg::CNT_W-1:0]      r_cnt;

    logic        [sfe_pkg::SQ_W:0]         shifted;
    logic        [sfe_pkg::SQ_W:0]         diff;
    logic                                  q_bit;
    logic        [sfe_pkg::FACTOR_W+sfe_pkg::D_W-1:0] prod;
    logic                                  small_rem;
    logic                                  sq_over;

    // One restoring division step: bring down the next dividend bit.
    assign shifted = {r_part, r_quo[sfe_pkg::DATA_WIDTH-1]};
    assign diff    = shifted - {1'b0, r_sq};
    assign q_bit   = !diff[sfe_pkg::SQ_W];

    // Next outside factor, cut to its result width.
    assign prod = {{sfe_pkg::D_W{1'b0}}, r_factor} * {{sfe_pkg::FACTOR_W{1'b0}}, r_d};

    // Termination: radicand below four, or d squared above the radicand.
    assign small_rem = (r_rem < $signed(sfe_pkg::DATA_WIDTH'(4)));
    assign sq_over   = ({{(sfe_pkg::DATA_WIDTH){1'b0}}, r_sq}
                        > {{(sfe_pkg::SQ_W){1'b0}}, $unsigned(r_rem)});

    assign o_status.finish   = small_rem || sq_over;
    assign o_status.div_last = (r_cnt == sfe_pkg::CNT_W'(sfe_pkg::DATA_WIDTH - 1));

    // Division step counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_cmd.div_init) begin
            r_cnt <= '0;
        end else if (i_cmd.div_step) begin
            r_cnt <= r_cnt + 1'b1;
        end
    end

    // Working registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_rem    <= i_radicand;
            r_d      <= sfe_pkg::D_W'(2);
            r_factor <= sfe_pkg::FACTOR_W'(1);
        end
        if (i_cmd.square) begin
            r_sq <= {{sfe_pkg::D_W{1'b0}}, r_d} * {{sfe_pkg::D_W{1'b0}}, r_d};
        end
        if (i_cmd.div_init) begin
            r_part <= '0;
            r_quo  <= $unsigned(r_rem);
        end
        if (i_cmd.div_step) begin
            r_part <= q_bit ? diff[sfe_pkg::SQ_W-1:0] : shifted[sfe_pkg::SQ_W-1:0];
            r_quo  <= {r_quo[sfe_pkg::DATA_WIDTH-2:0], q_bit};
        end
        if (i_cmd.test) begin
            // Exact division: keep d for another try; otherwise move on.
            if (r_part == '0) begin
                r_rem    <= $signed(r_quo);
                r_factor <= prod[sfe_pkg::FACTOR_W-1:0];
            end else begin
                r_d <= r_d + 1'b1;
            end
        end
    end

    assign o_outside_factor     = r_factor;
    assign o_remaining_radicand = sfe_pkg::OUT_RAD_W'(r_rem);

endmodule
